// ===== sv/yee_lossy_dielectric_update_unit_defines.svh =====
// Assertion helpers shared by the update unit.
`ifndef YEE_LOSSY_DIELECTRIC_UPDATE_UNIT_DEFINES_SVH
`define YEE_LOSSY_DIELECTRIC_UPDATE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define YLDU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("yldu assertion failed");

// next-cycle implication, disabled while in reset
`define YLDU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("yldu assertion failed");

`endif

// ===== sv/yldu_pkg.sv =====
package yldu_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int DATA_W    = 32;
   localparam int COEF_W    = 32;
   localparam int REG_IDX_W = 3;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [COEF_W-1:0]        coef_type;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_INV_DX  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_INV_DY  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_INV_DZ  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_E_DECAY = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_E_GAIN  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_H_GAIN  = 3'd5;

   // 1.0 in Q16.16
   localparam coef_type COEF_RESET = 32'h0001_0000;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic CMD_ELECTRIC = 1'b0;
   localparam logic CMD_MAGNETIC = 1'b1;

endpackage

// ===== sv/yldu_gain_mul.sv =====
// Two-stage curl * gain magnitude product, rounded half away from zero,
// clamped at 2^(64-FRAC_BITS).
module yldu_gain_mul #(
   parameter int FRAC_BITS = yldu_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic [66-FRAC_BITS-1:0]       curl_mag,
   input  logic [yldu_pkg::COEF_W-1:0]   gain_mag,
   output logic [65-FRAC_BITS-1:0]       prod_mag
);
   import yldu_pkg::*;

   localparam int CM_W = 66 - FRAC_BITS;
   localparam int LO_W = CM_W / 2;
   localparam int HI_W = CM_W - LO_W;
   localparam int F_W  = CM_W + COEF_W + 1;
   localparam int R_W  = F_W - FRAC_BITS;
   localparam int G_W  = 65 - FRAC_BITS;

   localparam logic [F_W-1:0] HALF  = F_W'(1) << (FRAC_BITS - 1);
   localparam logic [R_W-1:0] CAP_R = R_W'(1) << (64 - FRAC_BITS);

   logic [LO_W+COEF_W-1:0] pp_lo_in, pp_lo_ff;
   logic [HI_W+COEF_W-1:0] pp_hi_in, pp_hi_ff;
   logic [F_W-1:0]         full;
   logic [R_W-1:0]         rounded;
   logic [G_W-1:0]         prod_in, prod_ff;

   // split multiply: two narrow partial products
   always_comb begin
      pp_lo_in = curl_mag[LO_W-1:0] * gain_mag;
      pp_hi_in = curl_mag[CM_W-1:LO_W] * gain_mag;
   end

   always_comb begin
      full    = (F_W'(pp_hi_ff) << LO_W) + F_W'(pp_lo_ff) + HALF;
      rounded = full[F_W-1:FRAC_BITS];
      if (rounded > CAP_R) begin
         prod_in = CAP_R[G_W-1:0];
      end else begin
         prod_in = rounded[G_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      pp_lo_ff <= pp_lo_in;
      pp_hi_ff <= pp_hi_in;
      prod_ff  <= prod_in;
   end

   assign prod_mag = prod_ff;

endmodule

// ===== sv/yee_lossy_dielectric_update_unit.sv =====
// Yee FDTD cell update for a static lossy dielectric, signed fixed point.
// Input: pulse start with the req_ fields; the item is taken at a rising edge
// with start high and busy low. busy is high only during reset, so one item
// can be taken every cycle.
// Electric (command 0): new = old*e_decay + e_gain*(dk*invA - dj*invB)
// Magnetic (command 1): new = old + h_gain*(dj*invB - dk*invA)
// with dj = first_pos-first_neg, dk = second_pos-second_neg, and the axis
// picking (invA, invB): x (dy,dz), y (dz,dx), z (dx,dy); axis 3 acts as x.
// Output: rsp_valid strobes for one cycle with rsp_new_value/rsp_saturated;
// the receiver cannot hold it off. Throughput is one item per cycle
// outside reset, set by a seven-stage pipeline whose widest step is the
// curl*gain product, split into two partial products over two stages.
// Coefficients sit on the csr_ write port (index = register number) and
// must only be written while no item is in flight.
// Reset (synchronous) empties the pipeline and loads 1.0 into all six
// coefficient registers.
module yee_lossy_dielectric_update_unit #(
   parameter int FRAC_BITS = yldu_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_command,
   input  logic [1:0]                       req_axis,
   input  yldu_pkg::data_type               req_old_value,
   input  yldu_pkg::data_type               req_first_pos,
   input  yldu_pkg::data_type               req_first_neg,
   input  yldu_pkg::data_type               req_second_pos,
   input  yldu_pkg::data_type               req_second_neg,
   output logic                             rsp_valid,
   output yldu_pkg::data_type               rsp_new_value,
   output logic                             rsp_saturated,
   input  logic                             csr_write_enable,
   input  logic [yldu_pkg::REG_IDX_W-1:0]   csr_index,
   input  yldu_pkg::coef_type               csr_write_data
);
   import yldu_pkg::*;

`include "yee_lossy_dielectric_update_unit_defines.svh"

   // widths; all but DM_W and P1_W follow FRAC_BITS
   localparam int DM_W = DATA_W + 1;          // difference magnitude
   localparam int P1_W = DM_W + COEF_W;       // spacing product
   localparam int PO_W = 63 - FRAC_BITS;      // rounded old*decay magnitude
   localparam int TM_W = 65 - FRAC_BITS;      // rounded spacing term magnitude
   localparam int CM_W = TM_W + 1;            // curl magnitude
   localparam int B_W  = PO_W + 1;            // signed base term
   localparam int G_W  = 65 - FRAC_BITS;      // clamped gain product magnitude
   localparam int S_W  = G_W + 2;             // final signed sum

   localparam logic [P1_W:0]  HALF_P = (P1_W + 1)'(1) << (FRAC_BITS - 1);
   localparam logic [64:0]    HALF_O = 65'(1) << (FRAC_BITS - 1);
   localparam logic signed [S_W-1:0] MAX_S = S_W'(32'sh7fff_ffff);
   localparam logic signed [S_W-1:0] MIN_S = S_W'($signed(32'h8000_0000));

   function automatic coef_type mag32(input logic [31:0] v);
      mag32 = v[31] ? (32'd0 - v) : v;
   endfunction

   // ---------------- coefficient registers ----------------
   coef_type inv_dx_ff, inv_dy_ff, inv_dz_ff, e_decay_ff, e_gain_ff, h_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_dx_ff  <= COEF_RESET;
         inv_dy_ff  <= COEF_RESET;
         inv_dz_ff  <= COEF_RESET;
         e_decay_ff <= COEF_RESET;
         e_gain_ff  <= COEF_RESET;
         h_gain_ff  <= COEF_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_INV_DX:  inv_dx_ff  <= csr_write_data;
            REG_INV_DY:  inv_dy_ff  <= csr_write_data;
            REG_INV_DZ:  inv_dz_ff  <= csr_write_data;
            REG_E_DECAY: e_decay_ff <= csr_write_data;
            REG_E_GAIN:  e_gain_ff  <= csr_write_data;
            REG_H_GAIN:  h_gain_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // no backpressure: only reset holds the input off
   assign busy = reset;

   logic accept;
   assign accept = start && !busy;

   // ---------------- valid chain ----------------
   logic [7:1] valid_in, valid_ff;

   always_comb begin
      valid_in    = {valid_ff[6:1], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---------------- stage 1: differences, magnitudes, axis select -------
   logic signed [DM_W-1:0] dj, dk;
   logic                   s1_cmd_in, s1_cmd_ff;
   logic [DM_W-1:0]        s1_dj_mag_in, s1_dj_mag_ff, s1_dk_mag_in, s1_dk_mag_ff;
   logic                   s1_j_neg_in, s1_j_neg_ff, s1_k_neg_in, s1_k_neg_ff;
   coef_type               s1_inv_a_in, s1_inv_a_ff, s1_inv_b_in, s1_inv_b_ff;
   data_type               s1_old_in, s1_old_ff;
   coef_type               s1_old_mag_in, s1_old_mag_ff, s1_dec_mag_in, s1_dec_mag_ff;
   logic                   s1_o_neg_in, s1_o_neg_ff;

   always_comb begin
      dj = DM_W'(req_first_pos) - DM_W'(req_first_neg);
      dk = DM_W'(req_second_pos) - DM_W'(req_second_neg);
      s1_cmd_in    = req_command;
      s1_j_neg_in  = dj[DM_W-1];
      s1_k_neg_in  = dk[DM_W-1];
      s1_dj_mag_in = dj[DM_W-1] ? (DM_W'(0) - dj) : dj;
      s1_dk_mag_in = dk[DM_W-1] ? (DM_W'(0) - dk) : dk;
      case (req_axis)
         AXIS_Y: begin
            s1_inv_a_in = inv_dz_ff;
            s1_inv_b_in = inv_dx_ff;
         end
         AXIS_Z: begin
            s1_inv_a_in = inv_dx_ff;
            s1_inv_b_in = inv_dy_ff;
         end
         default: begin   // x, and the unused code
            s1_inv_a_in = inv_dy_ff;
            s1_inv_b_in = inv_dz_ff;
         end
      endcase
      s1_old_in     = req_old_value;
      s1_old_mag_in = mag32(req_old_value);
      s1_dec_mag_in = mag32(e_decay_ff);
      s1_o_neg_in   = req_old_value[DATA_W-1] ^ e_decay_ff[COEF_W-1];
   end

   // ---------------- stage 2: products ----------------
   logic [P1_W-1:0] s2_pj_in, s2_pj_ff, s2_pk_in, s2_pk_ff;
   logic [63:0]     s2_po_in, s2_po_ff;
   logic            s2_cmd_ff, s2_j_neg_ff, s2_k_neg_ff, s2_o_neg_ff;
   data_type        s2_old_ff;

   always_comb begin
      s2_pj_in = s1_dj_mag_ff * s1_inv_b_ff;
      s2_pk_in = s1_dk_mag_ff * s1_inv_a_ff;
      s2_po_in = s1_old_mag_ff * s1_dec_mag_ff;
   end

   // ---------------- stage 3: rounding ----------------
   logic [P1_W:0]   rj, rk;
   logic [64:0]     ro;
   logic [TM_W-1:0] s3_mj_in, s3_mj_ff, s3_mk_in, s3_mk_ff;
   logic [PO_W-1:0] s3_mo_in, s3_mo_ff;
   logic            s3_cmd_ff, s3_j_neg_ff, s3_k_neg_ff, s3_o_neg_ff;
   data_type        s3_old_ff;

   always_comb begin
      rj = (P1_W + 1)'(s2_pj_ff) + HALF_P;
      rk = (P1_W + 1)'(s2_pk_ff) + HALF_P;
      ro = 65'(s2_po_ff) + HALF_O;
      s3_mj_in = rj[TM_W+FRAC_BITS-1:FRAC_BITS];
      s3_mk_in = rk[TM_W+FRAC_BITS-1:FRAC_BITS];
      s3_mo_in = ro[PO_W+FRAC_BITS-1:FRAC_BITS];
   end

   // ---------------- stage 4: curl, base term, gain select ----------------
   logic [CM_W-1:0]        c_sum, c_d1, c_d2;
   logic                   curl_neg;
   coef_type               gain;
   logic [CM_W-1:0]        s4_curl_mag_in, s4_curl_mag_ff;
   coef_type               s4_gain_mag_in, s4_gain_mag_ff;
   logic                   s4_neg_in, s4_neg_ff;
   logic signed [B_W-1:0]  s4_base_in, s4_base_ff;

   always_comb begin
      // curl = +-mk -(+-mj): same signs subtract, opposite signs add
      c_sum = CM_W'(s3_mk_ff) + CM_W'(s3_mj_ff);
      c_d1  = CM_W'(s3_mk_ff) - CM_W'(s3_mj_ff);
      c_d2  = CM_W'(s3_mj_ff) - CM_W'(s3_mk_ff);
      if (s3_k_neg_ff != s3_j_neg_ff) begin
         s4_curl_mag_in = c_sum;
         curl_neg       = s3_k_neg_ff;
      end else if (c_d1[CM_W-1]) begin
         s4_curl_mag_in = c_d2;
         curl_neg       = !s3_k_neg_ff;
      end else begin
         s4_curl_mag_in = c_d1;
         curl_neg       = s3_k_neg_ff;
      end
      // magnetic update uses the negated curl
      gain           = (s3_cmd_ff == CMD_MAGNETIC) ? h_gain_ff : e_gain_ff;
      s4_gain_mag_in = mag32(gain);
      s4_neg_in      = curl_neg ^ gain[COEF_W-1] ^ (s3_cmd_ff == CMD_MAGNETIC);
      if (s3_cmd_ff == CMD_MAGNETIC) begin
         s4_base_in = B_W'(s3_old_ff);
      end else if (s3_o_neg_ff) begin
         s4_base_in = B_W'(0) - $signed({1'b0, s3_mo_ff});
      end else begin
         s4_base_in = $signed({1'b0, s3_mo_ff});
      end
   end

   // ---------------- stages 5-6: gain product ----------------
   logic [G_W-1:0]        gprod_mag;
   logic                  s5_neg_ff, s6_neg_ff;
   logic signed [B_W-1:0] s5_base_ff, s6_base_ff;

   yldu_gain_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_gain_mul (
      .clock    (clock),
      .curl_mag (s4_curl_mag_ff),
      .gain_mag (s4_gain_mag_ff),
      .prod_mag (gprod_mag)
   );

   // ---------------- stage 7: final sum and saturation ----------------
   logic signed [S_W-1:0] base_s, gprod_s, total;
   data_type              new_value_in, new_value_ff;
   logic                  sat_in, sat_ff;

   always_comb begin
      base_s  = S_W'(s6_base_ff);
      gprod_s = $signed(S_W'(gprod_mag));
      total   = s6_neg_ff ? (base_s - gprod_s) : (base_s + gprod_s);
      if (total > MAX_S) begin
         new_value_in = MAX_S[DATA_W-1:0];
         sat_in       = 1'b1;
      end else if (total < MIN_S) begin
         new_value_in = MIN_S[DATA_W-1:0];
         sat_in       = 1'b1;
      end else begin
         new_value_in = total[DATA_W-1:0];
         sat_in       = 1'b0;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_cmd_ff      <= s1_cmd_in;
      s1_dj_mag_ff   <= s1_dj_mag_in;
      s1_dk_mag_ff   <= s1_dk_mag_in;
      s1_j_neg_ff    <= s1_j_neg_in;
      s1_k_neg_ff    <= s1_k_neg_in;
      s1_inv_a_ff    <= s1_inv_a_in;
      s1_inv_b_ff    <= s1_inv_b_in;
      s1_old_ff      <= s1_old_in;
      s1_old_mag_ff  <= s1_old_mag_in;
      s1_dec_mag_ff  <= s1_dec_mag_in;
      s1_o_neg_ff    <= s1_o_neg_in;

      s2_pj_ff       <= s2_pj_in;
      s2_pk_ff       <= s2_pk_in;
      s2_po_ff       <= s2_po_in;
      s2_cmd_ff      <= s1_cmd_ff;
      s2_j_neg_ff    <= s1_j_neg_ff;
      s2_k_neg_ff    <= s1_k_neg_ff;
      s2_o_neg_ff    <= s1_o_neg_ff;
      s2_old_ff      <= s1_old_ff;

      s3_mj_ff       <= s3_mj_in;
      s3_mk_ff       <= s3_mk_in;
      s3_mo_ff       <= s3_mo_in;
      s3_cmd_ff      <= s2_cmd_ff;
      s3_j_neg_ff    <= s2_j_neg_ff;
      s3_k_neg_ff    <= s2_k_neg_ff;
      s3_o_neg_ff    <= s2_o_neg_ff;
      s3_old_ff      <= s2_old_ff;

      s4_curl_mag_ff <= s4_curl_mag_in;
      s4_gain_mag_ff <= s4_gain_mag_in;
      s4_neg_ff      <= s4_neg_in;
      s4_base_ff     <= s4_base_in;

      s5_neg_ff      <= s4_neg_ff;
      s5_base_ff     <= s4_base_ff;
      s6_neg_ff      <= s5_neg_ff;
      s6_base_ff     <= s5_base_ff;

      new_value_ff   <= new_value_in;
      sat_ff         <= sat_in;
   end

   assign rsp_valid     = valid_ff[7];
   assign rsp_new_value = new_value_ff;
   assign rsp_saturated = sat_ff;

   // ---------------- assertions ----------------
   // every strobe traces back to an accepted item
   `YLDU_ASSERT_IMPL(a_strobe_has_item, clock, reset, rsp_valid, $past(accept, 7))
   // a clipped result sits at one of the two rails
   `YLDU_ASSERT_IMPL(a_sat_at_rail, clock, reset, rsp_valid && rsp_saturated, (rsp_new_value == MAX_S[DATA_W-1:0]) || (rsp_new_value == MIN_S[DATA_W-1:0]))
   // magnetic item with zero curl returns old value unclipped
   `YLDU_ASSERT_NEXT(a_zero_curl, clock, reset, accept && (req_command == CMD_MAGNETIC) && (req_first_pos == req_first_neg) && (req_second_pos == req_second_neg), ##6 (rsp_valid && !rsp_saturated && (rsp_new_value == $past(req_old_value, 7))))

endmodule
